[rtl/bloom_filter_insert_query_macros.svh]
// assertion macros for the bloom filter block
`ifndef BLOOM_FILTER_INSERT_QUERY_MACROS_SVH
`define BLOOM_FILTER_INSERT_QUERY_MACROS_SVH
// implication checked on every clock edge outside reset
`define BF_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// next-cycle implication checked outside reset
`define BF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

[rtl/bfiq_pkg.sv]
// shared types and constants for the bloom filter block
package bfiq_pkg;
   localparam int MaxBits     = 65536;
   localparam int MaxHashes   = 16;
   localparam int AddrW       = $clog2(MaxBits);
   localparam int SeedW       = $clog2(MaxHashes);
   localparam int BitsW       = 17;
   localparam int HashW       = 5;
   localparam int QDepth      = 2;

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   localparam logic CSR_BITS_IN_USE = 1'b0;
   localparam logic CSR_HASH_COUNT  = 1'b1;

   // queued work item between front and back
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] key;
   } item_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic busy;
      logic rsp_pending;
   } bstat_type;
endpackage

[rtl/bfiq_front.sv]
// front end: accepts request beats into a short queue
module bfiq_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bfiq_pkg::item_type in_item,
   output logic               q_valid,
   input  logic               q_ready,
   output bfiq_pkg::item_type q_item
);
   import bfiq_pkg::*;

   item_type   mem_ff [QDepth];
   logic [0:0] wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'(QDepth));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = mem_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_item;
   end
endmodule

[rtl/bfiq_back.sv]
// back end: hash sequencer, modulo unit and bit store
module bfiq_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [16:0]          bits_use,
   input  logic [4:0]           hash_use,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  bfiq_pkg::item_type   q_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_bit,
   output bfiq_pkg::bstat_type  stat
);
   import bfiq_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MIX1, ST_MIX2, ST_MIX3, ST_FIN1, ST_FIN2,
      ST_FIN3, ST_MOD, ST_READ, ST_CHECK, ST_RESP
   } state_type;

   state_type   state_ff;
   cmd_type     cmd_ff;
   logic [31:0] b_ff;     // mixed key block, shared by all seeds
   logic [31:0] h_ff;
   logic [SeedW:0] seed_ff;
   logic [AddrW:0] clr_ff;
   logic [32:0] rem_ff;
   logic [16:0] mod_ff;
   logic [5:0]  mstep_ff;
   logic        ans_ff;
   logic        rvalid_ff;
   logic        rdata_ff;
   logic [AddrW-1:0] pos_ff;

   logic        store_ff [MaxBits];
   logic        we;
   logic [AddrW-1:0] waddr;
   logic        wdata;

   logic [31:0] kb1, hmix, hf;
   logic [33:0] trial;
   logic        last_seed;

   assign q_ready   = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp_bit   = rdata_ff;
   assign stat.busy = (state_ff != ST_IDLE);
   assign stat.rsp_pending = rvalid_ff;
   assign last_seed = ({1'b0, seed_ff} + 6'd1) >= {1'b0, hash_use};

   // first rotate of the key block, then the seed mix
   assign kb1  = {b_ff[16:0], b_ff[31:17]};
   assign hmix = h_ff ^ b_ff;
   assign hf   = h_ff ^ (h_ff >> 16);
   // restoring division step: shift in the next hash bit, compare against modulus
   assign trial = {rem_ff[32:0], h_ff[31]} - {17'd0, mod_ff};

   // bit store write port
   always_comb begin
      we    = 1'b0;
      waddr = pos_ff;
      wdata = 1'b1;
      if (state_ff == ST_CLEAR) begin
         we = 1'b1; waddr = clr_ff[AddrW-1:0]; wdata = 1'b0;
      end else if (state_ff == ST_CHECK && cmd_ff == CMD_INSERT) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) store_ff[waddr] <= wdata;
      if (state_ff == ST_CHECK) ans_ff <= store_ff[pos_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         rvalid_ff <= 1'b0;
         rdata_ff  <= 1'b0;
      end else begin
         if (rvalid_ff && rsp_ready) rvalid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AddrW+1)'(MaxBits - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (q_valid && q_ready) begin
                  cmd_ff   <= q_item.cmd;
                  seed_ff  <= '0;
                  b_ff     <= q_item.key * 32'hcc9e2d51;
                  state_ff <= ST_MIX1;
               end
            end
            ST_MIX1: begin
               b_ff     <= kb1 * 32'h1b873593;
               state_ff <= ST_MIX2;
            end
            ST_MIX2: begin
               h_ff     <= 32'(seed_ff);
               state_ff <= ST_MIX3;
            end
            ST_MIX3: begin
               h_ff     <= ({hmix[18:0], hmix[31:19]} * 32'd5 + 32'he6546b64) ^ 32'd4;
               state_ff <= ST_FIN1;
            end
            ST_FIN1: begin
               h_ff     <= hf * 32'h85ebca6b;
               state_ff <= ST_FIN2;
            end
            ST_FIN2: begin
               h_ff     <= (h_ff ^ (h_ff >> 13)) * 32'hc2b2ae35;
               state_ff <= ST_FIN3;
            end
            ST_FIN3: begin
               h_ff     <= hf;
               rem_ff   <= '0;
               mstep_ff <= '0;
               if (bits_use == 17'd0) mod_ff <= 17'd1;
               else if (bits_use > 17'(MaxBits)) mod_ff <= 17'(MaxBits);
               else mod_ff <= bits_use;
               state_ff <= ST_MOD;
            end
            ST_MOD: begin
               // one quotient bit a cycle, hash bits msb first
               if (trial[33]) rem_ff <= {rem_ff[31:0], h_ff[31]};
               else rem_ff <= trial[32:0];
               h_ff     <= {h_ff[30:0], 1'b0};
               mstep_ff <= mstep_ff + 6'd1;
               if (mstep_ff == 6'd31) state_ff <= ST_READ;
            end
            ST_READ: begin
               pos_ff   <= rem_ff[AddrW-1:0];
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               state_ff <= ST_RESP;
            end
            ST_RESP: begin
               if (cmd_ff == CMD_QUERY && !ans_ff) begin
                  rvalid_ff <= 1'b1; rdata_ff <= 1'b0; state_ff <= ST_IDLE;
               end else if (last_seed) begin
                  if (cmd_ff == CMD_QUERY) begin
                     rvalid_ff <= 1'b1; rdata_ff <= 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end else begin
                  seed_ff  <= seed_ff + 1'b1;
                  state_ff <= ST_MIX2;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

[rtl/bloom_filter_insert_query.sv]
// top level of the bloom filter block
// Bloom filter over a 65536-bit store. Each request beat is an insert or a
// query of a 32-bit key; for seeds 0 to k-1 the key is hashed with 32-bit
// murmur3 and reduced modulo bits_in_use by a bit-serial divider. A
// two-entry queue decouples the request port from the hash sequencer. Each
// seed runs the hash finaliser, 32 divider steps, a store read and, for an
// insert, a write; a query stops at the first seed that meets a clear bit.
// After reset a clearing pass zeroes the store before the first item is
// processed; requests queue meanwhile.
module bloom_filter_insert_query (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // maybe_present, zero fill
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);
   import bfiq_pkg::*;
`include "bloom_filter_insert_query_macros.svh"

   logic [16:0] bits_ff;
   logic [4:0]  hash_ff;
   logic [4:0]  hash_use;
   item_type    in_item, q_item;
   logic        q_valid, q_ready, rsp_bit;
   bstat_type   stat;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff <= 17'd65536;
         hash_ff <= 5'd7;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BITS_IN_USE: bits_ff <= csr_wdata;
            CSR_HASH_COUNT:  hash_ff <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // hash count clamped to one .. maximum
   assign hash_use = (hash_ff == 5'd0) ? 5'd1 :
                     (hash_ff > 5'(MaxHashes)) ? 5'(MaxHashes) : hash_ff;

   assign in_item.cmd = cmd_type'(req_tuser);
   assign in_item.key = req_tdata;

   bfiq_front u_front (
      .clock, .reset,
      .in_valid (req_tvalid), .in_ready (req_tready), .in_item (in_item),
      .q_valid, .q_ready, .q_item
   );

   bfiq_back u_back (
      .clock, .reset,
      .bits_use (bits_ff),
      .hash_use (hash_use),
      .q_valid, .q_ready, .q_item,
      .rsp_valid (rsp_tvalid), .rsp_ready (rsp_tready), .rsp_bit, .stat
   );

   assign rsp_tdata = {7'd0, rsp_bit};

   `BF_ASSERT_IMPLY(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, stat.rsp_pending, "response lost while stalled")
   `BF_ASSERT_NEXT(a_take_busy, clock, reset, q_valid && q_ready, stat.busy, "back end idle after taking item")
   `BF_ASSERT_IMPLY(a_no_take_pending, clock, reset, q_ready, !stat.rsp_pending, "item taken with response pending")
endmodule

[tb/bloom_filter_insert_query_tb.sv]
// testbench for the bloom filter insert and query block
`timescale 1ns / 100ps

module bloom_filter_insert_query_tb;
   import bfiq_pkg::*;

   localparam int SettleCycles = 2000;    // covers three queued items at the maximum hash count
   localparam int StallLimit   = 300000;  // covers the clearing pass after reset

   typedef struct {
      cmd_type     cmd;
      logic [31:0] key;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // key
   logic        req_tuser = 1'b0; // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // maybe_present, zero fill
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [16:0] csr_wdata = '0;

   beat_type    pending_beats[$];
   beat_type    cur_beat;
   logic        answer_q[$];
   logic [31:0] inserted_keys[$];
   bit          shadow_store[0:MaxBits-1];
   logic [16:0] shadow_bits = 17'd65536;
   logic [4:0]  shadow_hashes = 5'd7;
   bit          no_idle = 1'b0;
   int          error_count = 0;
   int          stall_cycles = 0;

   bloom_filter_insert_query dut (.*);

   always #2 clock = ~clock;

   function automatic logic [31:0] rotl(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   // murmur3 x86 32-bit over the four key bytes
   function automatic logic [31:0] murmur_key(logic [31:0] key, logic [31:0] seed);
      logic [31:0] h;
      logic [31:0] b;
      b = key * 32'hcc9e2d51;
      b = rotl(b, 15);
      b = b * 32'h1b873593;
      h = seed ^ b;
      h = rotl(h, 13);
      h = h * 32'd5 + 32'he6546b64;
      h = h ^ 32'd4;
      h = h ^ (h >> 16);
      h = h * 32'h85ebca6b;
      h = h ^ (h >> 13);
      h = h * 32'hc2b2ae35;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // update the shadow store and queue the answer for a query
   task automatic apply_to_filter(beat_type b);
      logic [31:0] m;
      logic [31:0] k;
      logic [31:0] pos;
      logic        hit;
      m = 32'(shadow_bits);
      if (m == 0) m = 1;
      if (m > MaxBits) m = MaxBits;
      k = 32'(shadow_hashes);
      if (k == 0) k = 1;
      if (k > MaxHashes) k = MaxHashes;
      hit = 1'b1;
      for (int s = 0; s < k; s++) begin
         pos = murmur_key(b.key, s) % m;
         if (b.cmd == CMD_INSERT) begin
            shadow_store[pos] = 1'b1;
         end else if (!shadow_store[pos]) begin
            hit = 1'b0;
            break;
         end
      end
      if (b.cmd == CMD_QUERY) answer_q.push_back(hit);
   endtask

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // request driver
   always @(posedge clock) begin
      logic hold;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         hold = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) apply_to_filter(cur_beat);
         if (!hold) begin
            if (pending_beats.size() > 0 && (no_idle || $urandom_range(99) >= 7)) begin
               cur_beat = pending_beats.pop_front();
               req_tdata <= cur_beat.key;
               req_tuser <= cur_beat.cmd;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               report($sformatf("unexpected beat %0h", rsp_tdata));
            end else if (rsp_tdata[0] !== answer_q.pop_front()) begin
               report($sformatf("maybe_present wrong, got %0b", rsp_tdata[0]));
            end
         end
         rsp_tready <= no_idle || $urandom_range(99) >= 7;
      end
   end

   // watchdog on handshake inactivity
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= StallLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic add_beat(cmd_type cmd, logic [31:0] key);
      beat_type b;
      b.cmd = cmd;
      b.key = key;
      pending_beats.push_back(b);
      if (cmd == CMD_INSERT) inserted_keys.push_back(key);
   endtask

   // wait for every result, then let the queued inserts drain
   task automatic wait_idle();
      wait (pending_beats.size() == 0 && !req_tvalid);
      wait (answer_q.size() == 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [16:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_BITS_IN_USE) shadow_bits = value;
      else shadow_hashes = value[4:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // inserts and queries, mostly of fresh keys, some of known keys
   task automatic random_phase(int count);
      logic [31:0] key;
      for (int i = 0; i < count; i++) begin
         if (inserted_keys.size() > 0 && $urandom_range(99) < 40)
            key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
         else
            key = $urandom;
         add_beat($urandom_range(1) ? CMD_QUERY : CMD_INSERT, key);
      end
   endtask

   // stimulus sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_BITS_IN_USE, 17'd65536);
      write_csr(CSR_HASH_COUNT, 17'd7);
      // directed: extreme keys, query before and after insert
      add_beat(CMD_QUERY, 32'h0000_0000);
      add_beat(CMD_INSERT, 32'h0000_0000);
      add_beat(CMD_QUERY, 32'h0000_0000);
      add_beat(CMD_INSERT, 32'hffff_ffff);
      add_beat(CMD_QUERY, 32'hffff_ffff);
      add_beat(CMD_QUERY, 32'h7fff_ffff);
      add_beat(CMD_INSERT, 32'h7fff_ffff);
      add_beat(CMD_QUERY, 32'h7fff_ffff);
      add_beat(CMD_INSERT, 32'h8000_0000);
      add_beat(CMD_QUERY, 32'h8000_0000);
      add_beat(CMD_QUERY, 32'h0000_0001);
      add_beat(CMD_INSERT, 32'haaaa_aaaa);
      add_beat(CMD_QUERY, 32'h5555_5555);
      add_beat(CMD_INSERT, 32'h5555_5555);
      add_beat(CMD_QUERY, 32'haaaa_aaaa);
      add_beat(CMD_QUERY, 32'h5555_5555);
      wait_idle();
      write_csr(CSR_BITS_IN_USE, 17'd1000);
      write_csr(CSR_HASH_COUNT, 17'd16);
      random_phase(200);
      wait_idle();
      // zero bit count and zero hash count both act as one
      write_csr(CSR_BITS_IN_USE, 17'd0);
      write_csr(CSR_HASH_COUNT, 17'd0);
      random_phase(40);
      wait_idle();
      // oversized settings clamp to the maxima
      write_csr(CSR_BITS_IN_USE, 17'h1ffff);
      write_csr(CSR_HASH_COUNT, 17'd31);
      random_phase(100);
      wait_idle();
      no_idle = 1'b1;
      write_csr(CSR_BITS_IN_USE, 17'd65536);
      write_csr(CSR_HASH_COUNT, 17'd1);
      random_phase(200);
      wait_idle();
      no_idle = 1'b0;
      write_csr(CSR_BITS_IN_USE, 17'd8);
      write_csr(CSR_HASH_COUNT, 17'd3);
      random_phase(60);
      wait_idle();
      // grow without clearing, older bits stay behind
      write_csr(CSR_BITS_IN_USE, 17'd40000);
      write_csr(CSR_HASH_COUNT, 17'd5);
      random_phase(200);
      wait_idle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
